// ===== rtl/core/acv_pkg.sv =====
// ----------------------------------------------------------------------------
// Animation clip validator package
// Shared constants, the byte transfer struct and the signature lookups.
// ----------------------------------------------------------------------------
package acv_pkg;

  localparam int FRAME_TABLE_DEPTH = 128;
  localparam int HDR_BYTES         = 16;
  localparam int ENTRY_BYTES       = 8;
  localparam int MAX_FRAMES        = 120;
  localparam int MIN_FRAME_SIZE    = 86;
  localparam int FRAME_DIM         = 160;
  localparam int MIN_CLIP_BYTES    = 20;

  localparam logic [7:0] MAGIC_0   = 8'h89;
  localparam logic [7:0] MAGIC_1   = 8'h45;  // 'E'
  localparam logic [7:0] MAGIC_2   = 8'h41;  // 'A'
  localparam logic [7:0] MAGIC_3   = 8'h46;  // 'F'

  localparam logic [7:0] SIG_SYNC  = 8'h5a;
  localparam logic [7:0] SIG_UNDER = 8'h5f;  // '_'
  localparam logic [7:0] SIG_S     = 8'h53;  // 'S'
  localparam logic [7:0] SIG_ZERO  = 8'h00;
  localparam logic [7:0] SIG_DEPTH = 8'h04;
  localparam logic [7:0] DIM_LO    = 8'(FRAME_DIM % 256);
  localparam logic [7:0] DIM_HI    = 8'(FRAME_DIM / 256);

  // One byte transfer handed from the port logic to the parser.
  typedef struct packed {
    logic       take;
    logic [7:0] data;
    logic       last;
  } acv_xfer_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = MAGIC_0;
      2'd1: m = MAGIC_1;
      2'd2: m = MAGIC_2;
      2'd3: m = MAGIC_3;
      default: m = MAGIC_0;
    endcase
    return m;
  endfunction

  // Checks one byte of a frame's 16-byte header; unlisted bytes are free.
  function automatic logic frame_sig_ok(input logic [3:0] k, input logic [7:0] b);
    logic ok;
    case (k)
      4'd0, 4'd1:   ok = (b == SIG_SYNC);
      4'd2:         ok = (b == SIG_UNDER);
      4'd3:         ok = (b == SIG_S);
      4'd4:         ok = (b == SIG_ZERO);
      4'd11:        ok = (b == SIG_DEPTH);
      4'd12, 4'd14: ok = (b == DIM_LO);
      4'd13, 4'd15: ok = (b == DIM_HI);
      default:      ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/core/acv_parser.sv =====
// ----------------------------------------------------------------------------
// Clip parser
// Walks header, frame table and frame data one byte per transfer, keeps the
// running checks and forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module acv_parser #(
  parameter int FRAME_TABLE_DEPTH = acv_pkg::FRAME_TABLE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  acv_pkg::acv_xfer_t xfer,
  input  logic [6:0]        expected_frames,
  output logic              verdict
);

  localparam int IDX_W = $clog2(FRAME_TABLE_DEPTH);

  logic [31:0] pos, pos_next;
  logic [6:0]  hdr_count, hdr_count_next;
  logic        hdr_count_hi_zero, hdr_count_hi_zero_next;
  logic [31:0] hdr_checksum, hdr_checksum_next;
  logic [31:0] hdr_paylen, hdr_paylen_next;
  logic [31:0] sum, sum_next;
  logic [31:0] word, word_next;
  logic [31:0] total, total_next;
  logic [31:0] size_hold, size_hold_next;
  logic [IDX_W-1:0] cursor, cursor_next;
  logic [31:0] fbc, fbc_next;
  logic        failed, failed_next;

  logic [31:0] frame_mem [FRAME_TABLE_DEPTH];
  logic [31:0] rd_size;
  logic        mem_we;
  logic [IDX_W-1:0] mem_waddr;

  logic [10:0] region;
  logic [9:0]  rel;
  logic [32:0] total_add;
  logic [31:0] fbc_inc;
  logic [32:0] tile_end;
  logic [32:0] clip_len;

  assign region    = {1'b0, hdr_count, 3'b000} + 11'(acv_pkg::HDR_BYTES);
  assign rel       = pos[9:0] - 10'(acv_pkg::HDR_BYTES);
  assign total_add = {1'b0, total} + {1'b0, size_hold};
  assign fbc_inc   = fbc + 32'd1;
  assign tile_end  = {1'b0, total} + 33'(region);
  assign clip_len  = {1'b0, pos} + 33'd1;
  assign mem_waddr = IDX_W'(rel[9:3]);

  always_comb begin
    pos_next               = pos;
    hdr_count_next         = hdr_count;
    hdr_count_hi_zero_next = hdr_count_hi_zero;
    hdr_checksum_next      = hdr_checksum;
    hdr_paylen_next        = hdr_paylen;
    sum_next               = sum;
    word_next              = word;
    total_next             = total;
    size_hold_next         = size_hold;
    cursor_next            = cursor;
    fbc_next               = fbc;
    failed_next            = failed;
    mem_we                 = 1'b0;
    verdict                = 1'b0;

    if (xfer.take) begin
      if (!failed) begin
        if (pos < 32'd4) begin
          if (xfer.data != acv_pkg::magic_byte(pos[1:0])) failed_next = 1'b1;
        end else if (pos < 32'(acv_pkg::HDR_BYTES)) begin
          word_next = {xfer.data, word[31:8]};
          if (pos[1:0] == 2'd3) begin
            unique case (pos[3:2])
              2'd1: begin
                hdr_count_next         = word_next[6:0];
                hdr_count_hi_zero_next = (word_next[31:7] == '0);
              end
              2'd2: hdr_checksum_next = word_next;
              2'd3: hdr_paylen_next   = word_next;
              default: ;
            endcase
          end
          // The frame count is judged once the whole header is in.
          if (pos[3:0] == 4'd15) begin
            if (!hdr_count_hi_zero || hdr_count != expected_frames ||
                hdr_count == 7'd0 || hdr_count > 7'(acv_pkg::MAX_FRAMES))
              failed_next = 1'b1;
          end
        end else begin
          sum_next = sum + 32'(xfer.data);
          if (pos < 32'(region)) begin
            word_next = {xfer.data, word[31:8]};
            if (rel[2:0] == 3'd3) begin
              mem_we         = 1'b1;
              size_hold_next = word_next;
              if (word_next < 32'(acv_pkg::MIN_FRAME_SIZE)) failed_next = 1'b1;
            end else if (rel[2:0] == 3'd7) begin
              if (word_next != total) failed_next = 1'b1;
              if (total_add[32]) failed_next = 1'b1;
              else total_next = total_add[31:0];
            end
          end else if (cursor < IDX_W'(hdr_count)) begin
            if (fbc[31:4] == '0 && !acv_pkg::frame_sig_ok(fbc[3:0], xfer.data))
              failed_next = 1'b1;
            if (fbc_inc == rd_size) begin
              cursor_next = cursor + 1'b1;
              fbc_next    = '0;
            end else begin
              fbc_next = fbc_inc;
            end
          end
        end
      end

      if (xfer.last) begin
        // A last byte inside the table leaves region >= length, so the
        // tiling sum can use the settled total.
        verdict = !failed_next &&
                  pos >= 32'(acv_pkg::MIN_CLIP_BYTES - 1) &&
                  hdr_paylen_next == pos - 32'(acv_pkg::HDR_BYTES - 1) &&
                  32'(region) <= pos &&
                  sum_next == hdr_checksum_next &&
                  tile_end == clip_len;
        pos_next               = '0;
        hdr_count_next         = '0;
        hdr_count_hi_zero_next = 1'b1;
        hdr_checksum_next      = '0;
        hdr_paylen_next        = '0;
        sum_next               = '0;
        word_next              = '0;
        total_next             = '0;
        size_hold_next         = '0;
        cursor_next            = '0;
        fbc_next               = '0;
        failed_next            = 1'b0;
      end else if (pos == '1) begin
        failed_next = 1'b1;
      end else begin
        pos_next = pos + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos               <= '0;
      hdr_count         <= '0;
      hdr_count_hi_zero <= 1'b1;
      hdr_checksum      <= '0;
      hdr_paylen        <= '0;
      sum               <= '0;
      word              <= '0;
      total             <= '0;
      size_hold         <= '0;
      cursor            <= '0;
      fbc               <= '0;
      failed            <= 1'b0;
    end else begin
      pos               <= pos_next;
      hdr_count         <= hdr_count_next;
      hdr_count_hi_zero <= hdr_count_hi_zero_next;
      hdr_checksum      <= hdr_checksum_next;
      hdr_paylen        <= hdr_paylen_next;
      sum               <= sum_next;
      word              <= word_next;
      total             <= total_next;
      size_hold         <= size_hold_next;
      cursor            <= cursor_next;
      fbc               <= fbc_next;
      failed            <= failed_next;
    end
  end

  // Frame size memory: written from the table, read at the frame cursor.
  // The read address follows the cursor's next value so the size of the
  // current frame is ready when its bytes arrive.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= word_next;
    end
    rd_size <= frame_mem[cursor_next];
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    xfer.take && xfer.last |=> pos == '0 && !failed && cursor == '0)
    else $error("clip state not cleared after last byte");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= IDX_W'(hdr_count))
    else $error("frame cursor ran past the frame count");
`endif

endmodule

// ===== rtl/core/animation_clip_validator.sv =====
// The verdict is registered: it is valid in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle; input stalls only while a verdict waits
// in the full output register and the output side stalls.
// Frame sizes sit in a FRAME_TABLE_DEPTH x 32 memory, one write and one read port.
// Reset clears the clip state and out_valid, and sets expected_frames to 1;
// the frame size memory keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Animation clip validator
// Byte stream handshake, expected frame count register and verdict register.
// ----------------------------------------------------------------------------
module animation_clip_validator #(
  parameter int FRAME_TABLE_DEPTH = acv_pkg::FRAME_TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       clip_valid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0]         expected_frames;
  acv_pkg::acv_xfer_t xfer;
  logic               verdict;
  logic               in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  assign xfer.take = in_take;
  assign xfer.data = data_byte;
  assign xfer.last = last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_frames <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      expected_frames <= cfg_data;
    end
  end

  acv_parser #(
    .FRAME_TABLE_DEPTH(FRAME_TABLE_DEPTH)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .xfer            (xfer),
    .expected_frames (expected_frames),
    .verdict         (verdict)
  );

  // A new verdict may load in the same cycle the old one transfers out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && last_byte) begin
      clip_valid <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_verdict_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("no verdict after last byte transfer");

  a_verdict_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(in_valid && last_byte) |=> !out_valid)
    else $error("verdict repeated after transfer");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Animation clip validator testbench
// Streams whole clips into the byte port, some well formed, some damaged and
// some pure noise, under three sender/receiver idling mixes. A scoreboard
// mirrors the clip checks byte by byte and compares every verdict in order.
// ----------------------------------------------------------------------------
module tb;
  import acv_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_PHASES  = 9;
  localparam bit [7:0] CLIP_MAGIC [4] = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
  localparam bit [6:0] PHASE_FRAMES [RAND_PHASES] = '{2, 1, 0, 3, 127, 1, 121, 4, 2};

  typedef enum int {
    FLAW_MAGIC, FLAW_COUNT, FLAW_SUM, FLAW_LENGTH, FLAW_OFFSET,
    FLAW_SIZE, FLAW_SIG, FLAW_CUT, FLAW_EXTRA, FLAW_FLIP
  } clip_flaw_e;

  class verdict_scoreboard;
    bit [6:0]  frames_cfg;
    bit [31:0] pos, hdr_count, hdr_sum, hdr_len, byte_sum, word, offset_total, frame_bytes;
    bit [31:0] size_table [FRAME_TABLE_DEPTH];
    bit [7:0]  cursor;
    bit        failed;
    bit        predicted_verdicts [$];
    int        errors, clips, bytes, passes, verdicts_seen;

    function new();
      frames_cfg = 1;
      clear_clip();
    endfunction

    function void clear_clip();
      pos = 0;
      hdr_count = 0;
      hdr_sum = 0;
      hdr_len = 0;
      byte_sum = 0;
      word = 0;
      offset_total = 0;
      cursor = 0;
      frame_bytes = 0;
      failed = 0;
    endfunction

    // Bytes of a frame's own header that carry a fixed value.
    static function bit fixed_frame_byte(input int unsigned k, output bit [7:0] v);
      v = 8'h00;
      case (k)
        0, 1:   v = SIG_SYNC;
        2:      v = SIG_UNDER;
        3:      v = SIG_S;
        4:      v = SIG_ZERO;
        11:     v = SIG_DEPTH;
        12, 14: v = DIM_LO;
        13, 15: v = DIM_HI;
        default: return 0;
      endcase
      return 1;
    endfunction

    function void absorb(bit [7:0] b);
      bit [31:0] region, rel, idx, sz;
      bit [7:0]  sig;
      if (pos < 4) begin
        if (b != CLIP_MAGIC[pos[1:0]]) failed = 1;
        return;
      end
      if (pos < HDR_BYTES) begin
        word = {b, word[31:8]};
        if (pos[1:0] == 2'd3) begin
          case (pos[3:2])
            2'd1: hdr_count = word;
            2'd2: hdr_sum = word;
            default: hdr_len = word;
          endcase
        end
        if (pos == HDR_BYTES - 1 && (hdr_count != {25'd0, frames_cfg} || hdr_count == 0 ||
            hdr_count > MAX_FRAMES))
          failed = 1;
        return;
      end
      byte_sum += b;
      region = HDR_BYTES + hdr_count * ENTRY_BYTES;
      if (pos < region) begin
        rel = pos - HDR_BYTES;
        idx = rel >> 3;
        word = {b, word[31:8]};
        if (idx >= FRAME_TABLE_DEPTH) begin
          failed = 1;
          return;
        end
        if (rel[2:0] == 3'd3) begin
          size_table[idx] = word;
          if (word < MIN_FRAME_SIZE) failed = 1;
        end else if (rel[2:0] == 3'd7) begin
          sz = size_table[idx];
          if (word != offset_total) failed = 1;
          // The running offset may not wrap past 32 bits.
          if (sz > ~offset_total) failed = 1;
          else offset_total += sz;
        end
        return;
      end
      if (cursor >= hdr_count || cursor >= FRAME_TABLE_DEPTH) return;
      if (frame_bytes < HDR_BYTES && fixed_frame_byte(frame_bytes, sig) && b != sig) failed = 1;
      frame_bytes++;
      if (frame_bytes == size_table[cursor]) begin
        cursor++;
        frame_bytes = 0;
      end
    endfunction

    function bit judge();
      bit [63:0] len, region;
      len = {32'd0, pos} + 64'd1;
      region = 64'd16 + {32'd0, hdr_count} * 64'd8;
      if (failed || len < MIN_CLIP_BYTES) return 0;
      if ({32'd0, hdr_len} != len - 64'd16) return 0;
      if (region >= len) return 0;
      if (byte_sum != hdr_sum) return 0;
      return region + {32'd0, offset_total} == len;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      bit v;
      bytes++;
      if (!failed) absorb(b);
      if (last) begin
        v = judge();
        predicted_verdicts.push_back(v);
        clips++;
        passes += v;
        clear_clip();
      end else if (pos == 32'hFFFF_FFFF) begin
        failed = 1;
      end else begin
        pos++;
      end
    endfunction

    function void check_verdict(bit got);
      bit want;
      verdicts_seen++;
      if (predicted_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("verdict %0d: none pending, got %0b", verdicts_seen, got);
        return;
      end
      want = predicted_verdicts.pop_front();
      if (want != got) begin
        errors++;
        if (errors <= 10)
          $display("verdict %0d: expected clip_valid %0b, got %0b", verdicts_seen, want, got);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_stall;
  logic       clip_valid;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  verdict_scoreboard board;
  bit [7:0]    clip_q [$];
  int unsigned frame_starts [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          idle_cycles;

  animation_clip_validator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .clip_valid(clip_valid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Output transfers are checked before the input transfer of the same edge,
  // since a verdict always belongs to an earlier last byte.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) board.check_verdict(clip_valid);
      if (in_valid && !in_stall) board.note_byte(data_byte, last_byte);
      if (cfg_valid && cfg_ready) board.frames_cfg = cfg_data;
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("animation_clip_validator regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_word(input bit [31:0] w);
    for (int i = 0; i < 4; i++) clip_q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_word(input int unsigned at, input bit [31:0] w);
    for (int i = 0; i < 4; i++) clip_q[at + i] = w[8*i +: 8];
  endtask

  task automatic flip_bit(input int unsigned at);
    clip_q[at] = clip_q[at] ^ (8'd1 << $urandom_range(0, 7));
  endtask

  task automatic trim_clip(input int unsigned n);
    while (clip_q.size() > n) void'(clip_q.pop_back());
  endtask

  // Fills in the checksum and payload length from the bytes after the header.
  task automatic seal_header();
    bit [31:0] sum;
    sum = 0;
    for (int i = HDR_BYTES; i < clip_q.size(); i++) sum += clip_q[i];
    put_word(8, sum);
    put_word(12, clip_q.size() - HDR_BYTES);
  endtask

  // A consistent clip whose header announces hc frames; n frames are built.
  // A fixed_size of zero picks sizes at random, mostly near the minimum.
  task automatic build_clip(input bit [31:0] hc, input int n, input int unsigned fixed_size);
    int unsigned sizes [$];
    bit [31:0]   offset;
    bit [7:0]    v;
    clip_q.delete();
    frame_starts.delete();
    for (int i = 0; i < 4; i++) clip_q.push_back(CLIP_MAGIC[i]);
    push_word(hc);
    push_word(0);
    push_word(0);
    for (int i = 0; i < n; i++) begin
      if (fixed_size != 0) sizes.push_back(fixed_size);
      else if ($urandom_range(0, 9) == 0) sizes.push_back($urandom_range(MIN_FRAME_SIZE, 300));
      else sizes.push_back($urandom_range(MIN_FRAME_SIZE, MIN_FRAME_SIZE + 14));
    end
    offset = 0;
    foreach (sizes[i]) begin
      push_word(sizes[i]);
      push_word(offset);
      offset += sizes[i];
    end
    foreach (sizes[i]) begin
      frame_starts.push_back(clip_q.size());
      for (int k = 0; k < sizes[i]; k++) begin
        if (verdict_scoreboard::fixed_frame_byte(k, v)) clip_q.push_back(v);
        else clip_q.push_back($urandom_range(0, 255));
      end
    end
    seal_header();
  endtask

  task automatic make_noise();
    int unsigned n;
    n = $urandom_range(1, 24);
    clip_q.delete();
    frame_starts.delete();
    if ($urandom_range(0, 1)) for (int i = 0; i < 4; i++) clip_q.push_back(CLIP_MAGIC[i]);
    while (clip_q.size() < n) clip_q.push_back($urandom_range(0, 255));
  endtask

  task automatic damage_clip(input clip_flaw_e flaw);
    int unsigned n, k;
    bit [7:0]    v;
    n = frame_starts.size();
    if (n == 0 && flaw inside {FLAW_OFFSET, FLAW_SIZE, FLAW_SIG}) flaw = FLAW_FLIP;
    case (flaw)
      FLAW_MAGIC:  flip_bit($urandom_range(0, 3));
      FLAW_COUNT:  flip_bit($urandom_range(4, 7));
      FLAW_SUM:    flip_bit($urandom_range(8, 11));
      FLAW_LENGTH: flip_bit($urandom_range(12, 15));
      FLAW_OFFSET: flip_bit(HDR_BYTES + ENTRY_BYTES * $urandom_range(0, n - 1) + 4 +
                            $urandom_range(0, 3));
      FLAW_SIZE:   put_word(HDR_BYTES + ENTRY_BYTES * $urandom_range(0, n - 1),
                            $urandom_range(0, MIN_FRAME_SIZE - 1));
      FLAW_SIG: begin
        do k = $urandom_range(0, 15); while (!verdict_scoreboard::fixed_frame_byte(k, v));
        flip_bit(frame_starts[$urandom_range(0, n - 1)] + k);
      end
      FLAW_CUT:    trim_clip($urandom_range(1, clip_q.size() - 1));
      FLAW_EXTRA:  repeat ($urandom_range(1, 3)) clip_q.push_back($urandom_range(0, 255));
      default:     flip_bit($urandom_range(0, clip_q.size() - 1));
    endcase
  endtask

  // Called and left at a falling edge; valid stays high between clips.
  task automatic send_clip();
    for (int i = 0; i < clip_q.size(); i++) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid = 0;
        @(negedge clk);
      end
      in_valid = 1;
      data_byte = clip_q[i];
      last_byte = (i == clip_q.size() - 1);
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 0;
    while (board.predicted_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_expected_frames(input bit [6:0] v);
    drain();
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_clip(input bit [6:0] frames);
    bit [31:0]   hc;
    int          n;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      make_noise();
      send_clip();
      return;
    end
    if (frames >= 1 && frames <= MAX_FRAMES && $urandom_range(0, 9) != 0) hc = frames;
    else hc = $urandom_range(0, 5);
    n = (hc >= 1 && hc <= MAX_FRAMES) ? int'(hc) : $urandom_range(0, 2);
    build_clip(hc, n, 0);
    if (roll >= 60) damage_clip(clip_flaw_e'($urandom_range(FLAW_MAGIC, FLAW_FLIP)));
    send_clip();
  endtask

  initial begin
    board = new();
    rst = 1;
    in_valid = 0;
    data_byte = 0;
    last_byte = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = 0;
    send_idle_pct = 26;
    recv_stall_pct = 69;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed clips, starting on the reset value of expected_frames.
    build_clip(1, 1, MIN_FRAME_SIZE);
    send_clip();
    build_clip(1, 1, 255);
    send_clip();
    clip_q = '{8'h00};
    send_clip();
    clip_q = '{8'hFF};
    send_clip();
    // Clips that end inside the frame table, one byte below and at the minimum clip length.
    build_clip(1, 1, 0);
    trim_clip(MIN_CLIP_BYTES - 1);
    send_clip();
    build_clip(1, 1, 0);
    trim_clip(MIN_CLIP_BYTES);
    send_clip();
    for (int f = FLAW_MAGIC; f <= FLAW_FLIP; f++) begin
      build_clip(1, 1, 0);
      damage_clip(clip_flaw_e'(f));
      send_clip();
    end

    set_expected_frames(2);
    build_clip(2, 2, 0);
    send_clip();
    // Second table entry pushes the offset total past 32 bits.
    build_clip(2, 0, 0);
    push_word(32'hFFFF_FFF0);
    push_word(32'h0000_0000);
    push_word(32'h0000_0100);
    push_word(32'hFFFF_FFF0);
    repeat (8) clip_q.push_back($urandom_range(0, 255));
    seal_header();
    send_clip();

    set_expected_frames(MAX_FRAMES);
    build_clip(MAX_FRAMES, MAX_FRAMES, MIN_FRAME_SIZE);
    send_clip();
    set_expected_frames(0);
    build_clip(0, 1, 0);
    send_clip();
    set_expected_frames(127);
    build_clip(127, 1, 0);
    send_clip();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 26 : (ph < 6) ? 69 : 0;
      recv_stall_pct = (ph < 3) ? 69 : (ph < 6) ? 26 : 0;
      set_expected_frames(PHASE_FRAMES[ph]);
      repeat (5) random_clip(PHASE_FRAMES[ph]);
    end

    drain();
    $display("%0d clips (%0d bytes) streamed, %0d expected to pass, %0d mismatches",
             board.clips, board.bytes, board.passes, board.errors);
    $display("frame count setting swept from 0 through 127 under three idling mixes");
    if (board.errors == 0 && board.predicted_verdicts.size() == 0) begin
      $display("animation_clip_validator regression: pass");
    end else begin
      $display("animation_clip_validator regression: fail");
    end
    $finish;
  end

endmodule
